FILE: hdl/seconds_nanoseconds_time_register_top_assert.svh
// Assertion macros for the seconds and nanoseconds time register.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef SECONDS_NANOSECONDS_TIME_REGISTER_TOP_ASSERT_SVH
`define SECONDS_NANOSECONDS_TIME_REGISTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SNTR_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SNTR_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/sntr_pkg.sv
// Shared constants, codes and the controller command type for the time register.
// No dependencies.
`timescale 1ns / 1ps

package sntr_pkg;

	localparam int SEC_BITS_DEF = 48;
	localparam int NS_W         = 64;
	localparam int OSEC_W       = 48;
	localparam int NANO_W       = 30;
	localparam int MICRO_W      = 20;
	localparam int QUO_W        = 35;
	localparam int DIV_STEPS    = 5;

	localparam logic [NANO_W-1:0] NS_PER_SEC = 30'd1000000000;

	// One billion is two to the ninth times five to the ninth. The count shifted
	// down by nine places is multiplied by 2^75 / 5^9, rounded up, and the
	// product is shifted down by 75 places; exact for any 55-bit value.
	localparam logic [54:0] DIV_RECIP     = 55'd19342813113834067;
	localparam int          DIV_PRESHIFT  = 9;
	localparam int          DIV_POSTSHIFT = 11;

	// Reciprocal of one thousand scaled by 2^40, rounded up; exact for any
	// value below 2^30.
	localparam logic [30:0] MICRO_RECIP = 31'd1099511628;
	localparam int          MICRO_SHIFT = 40;

	localparam logic [2:0] OP_SET_NS     = 3'd0;
	localparam logic [2:0] OP_ADD_NS     = 3'd1;
	localparam logic [2:0] OP_SET_SEC_NS = 3'd2;
	localparam logic [2:0] OP_ADD_SEC    = 3'd3;
	localparam logic [2:0] OP_SUB_SEC_NS = 3'd4;
	localparam logic [2:0] OP_COMPARE    = 3'd5;
	localparam logic [2:0] OP_READ       = 3'd6;

	localparam logic [1:0] ORD_LESS    = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	localparam logic ERR_OK       = 1'b0;
	localparam logic ERR_NEGATIVE = 1'b1;

	typedef struct packed {
		logic load;
		logic div_step;
		logic apply;
		logic mul_lo;
		logic mul_hi;
		logic publish;
	} sntr_cmd_t;

endpackage

FILE: hdl/seconds_nanoseconds_time_register_top.sv
// An accepted word passes division, update, the products and publish; then done strobes.
// A new word is taken only while the controller is idle, one word at a time.
// Reset: arst_n clears the stored time to zero and returns the controller to idle.
// The receiver cannot stall; done is high for one cycle, results hold until replaced.
// Depends on sntr_pkg, sntr_ctrl, sntr_datapath and the assertion macro header.
`timescale 1ns / 1ps

`include "seconds_nanoseconds_time_register_top_assert.svh"

module seconds_nanoseconds_time_register_top #(
	parameter int SEC_BITS = sntr_pkg::SEC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        opcode,
	input  logic [sntr_pkg::NS_W-1:0]         operand_ns,
	input  logic [sntr_pkg::OSEC_W-1:0]       operand_sec,
	output logic                              done,
	output logic [sntr_pkg::NS_W-1:0]         total_ns,
	output logic [sntr_pkg::OSEC_W-1:0]       seconds_out,
	output logic [sntr_pkg::NANO_W-1:0]       nanos_out,
	output logic [sntr_pkg::MICRO_W-1:0]      micros_out,
	output logic                              is_zero,
	output logic [1:0]                        order,
	output logic                              error_code
);

	// The controller steps through one word at a time. A word is taken when
	// start is seen while the controller is idle; the operands are latched in
	// that cycle, so the sender may change them afterwards.
	//
	// The nanosecond operand is then divided by one billion in the divider.
	// Shifted down by nine places, it is multiplied by a scaled reciprocal of
	// five to the ninth in four 32-bit partial products, and a last step
	// forms the remainder from the quotient. The quotient carries into the
	// seconds and the remainder is the nanosecond part of the operand time.
	//
	// In the update cycle the operation is applied to the stored time. A
	// subtraction that would go negative leaves the time as it was and flags
	// an error. Seconds wrap at the width set by SEC_BITS.
	//
	// The MUL_LO and MUL_HI states form seconds times one billion from two
	// 32-bit halves and the microseconds by a scaled reciprocal, and the
	// publish state adds the pieces and loads the result registers, which hold
	// until the next word completes. done is high for exactly one cycle per
	// word, and the controller is idle again in that cycle, so a new word may
	// be taken at the edge that ends it.

	sntr_pkg::sntr_cmd_t cmd;

	sntr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	sntr_datapath #(
		.SEC_BITS (SEC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (opcode),
		.operand_ns  (operand_ns),
		.operand_sec (operand_sec),
		.done        (done),
		.total_ns    (total_ns),
		.seconds_out (seconds_out),
		.nanos_out   (nanos_out),
		.micros_out  (micros_out),
		.is_zero     (is_zero),
		.order       (order),
		.error_code  (error_code)
	);

	// An accepted word must put the controller to work at once.
	`SNTR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	// A result is only published once the controller has gone back to idle.
	`SNTR_ASSERT_NOW(a_done_idle, done, !busy, "done raised while busy")
	// Each word gives one result strobe, never two in a row.
	`SNTR_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")

endmodule

FILE: hdl/sntr_div.sv
// Division of a 64-bit nanosecond count by one billion by a scaled reciprocal, five steps.
// Depends on sntr_pkg.
`timescale 1ns / 1ps

module sntr_div (
	input  logic                                clk,
	input  logic                                load,
	input  logic                                step,
	input  logic [sntr_pkg::NS_W-1:0]           dividend,
	output logic [sntr_pkg::QUO_W-1:0]          quotient,
	output logic [sntr_pkg::NANO_W-1:0]         remainder
);

	localparam logic [2:0] PH_LO_LO = 3'd0;
	localparam logic [2:0] PH_LO_HI = 3'd1;
	localparam logic [2:0] PH_HI_LO = 3'd2;
	localparam logic [2:0] PH_HI_HI = 3'd3;
	localparam logic [2:0] PH_REM   = 3'd4;

	localparam int          PS   = sntr_pkg::DIV_PRESHIFT;
	localparam logic [31:0] M_LO = sntr_pkg::DIV_RECIP[31:0];
	localparam logic [22:0] M_HI = sntr_pkg::DIV_RECIP[54:32];

	logic [2:0]                  phase_q;
	logic [sntr_pkg::NS_W-1:0]   num_q;
	logic [56:0]                 acc_q;
	logic [sntr_pkg::QUO_W-1:0]  quo_q;
	logic [sntr_pkg::NANO_W-1:0] rem_q;
	logic [31:0]                 a_lo;
	logic [22:0]                 a_hi;
	logic [31:0]                 mul_a;
	logic [31:0]                 mul_b;
	logic [63:0]                 prod;
	logic [45:0]                 top_sum;

	// The shifted count is split into a 32-bit low and a 23-bit high half, as
	// is the reciprocal; one partial product is taken in each of four steps.
	assign a_lo = num_q[PS +: 32];
	assign a_hi = num_q[sntr_pkg::NS_W-1:PS+32];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (phase_q)
			PH_LO_LO: begin
				mul_a = a_lo;
				mul_b = M_LO;
			end
			PH_LO_HI: begin
				mul_a = a_lo;
				mul_b = 32'(M_HI);
			end
			PH_HI_LO: begin
				mul_a = 32'(a_hi);
				mul_b = M_LO;
			end
			PH_HI_HI: begin
				mul_a = 32'(a_hi);
				mul_b = 32'(M_HI);
			end
			PH_REM: begin
				mul_a = 32'(quo_q[sntr_pkg::NANO_W-1:0]);
				mul_b = 32'(sntr_pkg::NS_PER_SEC);
			end
			default: begin
			end
		endcase
	end

	assign prod    = 64'(mul_a) * 64'(mul_b);
	assign top_sum = 46'(acc_q[56:32]) + 46'(prod);

	// The remainder is below 2^30, so it is found from the low 30 bits alone.
	always_ff @(posedge clk) begin
		if (load) begin
			phase_q <= '0;
			num_q   <= dividend;
		end else if (step) begin
			phase_q <= phase_q + 3'd1;
			case (phase_q)
				PH_LO_LO: acc_q <= 57'(prod[63:32]);
				PH_LO_HI: acc_q <= acc_q + 57'(prod);
				PH_HI_LO: acc_q <= acc_q + 57'(prod);
				PH_HI_HI: quo_q <= top_sum[sntr_pkg::DIV_POSTSHIFT +: sntr_pkg::QUO_W];
				PH_REM:   rem_q <= num_q[sntr_pkg::NANO_W-1:0] - prod[sntr_pkg::NANO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: hdl/sntr_datapath.sv
// Datapath: operand latches, divider, stored time, update logic and output forms.
// Depends on sntr_pkg and sntr_div.
`timescale 1ns / 1ps

module sntr_datapath #(
	parameter int SEC_BITS = sntr_pkg::SEC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sntr_pkg::sntr_cmd_t               cmd,
	input  logic [2:0]                        opcode,
	input  logic [sntr_pkg::NS_W-1:0]         operand_ns,
	input  logic [sntr_pkg::OSEC_W-1:0]       operand_sec,
	output logic                              done,
	output logic [sntr_pkg::NS_W-1:0]         total_ns,
	output logic [sntr_pkg::OSEC_W-1:0]       seconds_out,
	output logic [sntr_pkg::NANO_W-1:0]       nanos_out,
	output logic [sntr_pkg::MICRO_W-1:0]      micros_out,
	output logic                              is_zero,
	output logic [1:0]                        order,
	output logic                              error_code
);

	localparam int QW  = sntr_pkg::QUO_W;
	localparam int NW  = sntr_pkg::NANO_W;
	localparam int OPW = ((SEC_BITS > QW) ? SEC_BITS : QW) + 1;

	logic [2:0]              opcode_q;
	logic [SEC_BITS-1:0]     osec_q;
	logic [SEC_BITS-1:0]     sec_q;
	logic [NW-1:0]           nanos_q;
	logic [1:0]              order_q;
	logic                    err_q;
	logic                    done_q;

	logic [QW-1:0]           quot;
	logic [NW-1:0]           rem;
	logic [63:0]             osec64;
	logic [OPW-1:0]          op_sec;
	logic [OPW-1:0]          sec_ext;
	logic [NW:0]             ns_sum;
	logic                    ns_carry;
	logic                    lt;
	logic                    eq;
	logic [SEC_BITS-1:0]     sec_d;
	logic [NW-1:0]           nanos_d;
	logic [1:0]              order_d;
	logic                    err_d;

	logic [63:0]             sec64;
	logic [61:0]             lo_prod_q;
	logic [31:0]             hi_prod_q;
	logic [60:0]             micro_prod_q;

	sntr_div u_div (
		.clk       (clk),
		.load      (cmd.load),
		.step      (cmd.div_step),
		.dividend  (operand_ns),
		.quotient  (quot),
		.remainder (rem)
	);

	assign osec64 = 64'(operand_sec);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opcode_q <= opcode;
			osec_q   <= osec64[SEC_BITS-1:0];
		end
	end

	// Operand time in full precision, so compare and subtract never wrap.
	assign op_sec   = OPW'(osec_q) + OPW'(quot);
	assign sec_ext  = OPW'(sec_q);
	assign ns_sum   = {1'b0, nanos_q} + {1'b0, rem};
	assign ns_carry = ns_sum >= {1'b0, sntr_pkg::NS_PER_SEC};
	assign lt       = (sec_ext < op_sec) || ((sec_ext == op_sec) && (nanos_q < rem));
	assign eq       = (sec_ext == op_sec) && (nanos_q == rem);

	always_comb begin
		sec_d   = sec_q;
		nanos_d = nanos_q;
		order_d = sntr_pkg::ORD_LESS;
		err_d   = sntr_pkg::ERR_OK;
		unique case (opcode_q)
			sntr_pkg::OP_SET_NS: begin
				sec_d   = SEC_BITS'(quot);
				nanos_d = rem;
			end
			sntr_pkg::OP_ADD_NS: begin
				nanos_d = ns_carry ? NW'(ns_sum - {1'b0, sntr_pkg::NS_PER_SEC}) : NW'(ns_sum);
				sec_d   = sec_q + SEC_BITS'(quot) + SEC_BITS'(ns_carry);
			end
			sntr_pkg::OP_SET_SEC_NS: begin
				sec_d   = SEC_BITS'(op_sec);
				nanos_d = rem;
			end
			sntr_pkg::OP_ADD_SEC: begin
				sec_d = sec_q + osec_q;
			end
			sntr_pkg::OP_SUB_SEC_NS: begin
				if (lt) begin
					err_d = sntr_pkg::ERR_NEGATIVE;
				end else if (nanos_q >= rem) begin
					nanos_d = nanos_q - rem;
					sec_d   = sec_q - SEC_BITS'(op_sec);
				end else begin
					nanos_d = nanos_q + sntr_pkg::NS_PER_SEC - rem;
					sec_d   = sec_q - SEC_BITS'(op_sec) - SEC_BITS'(1);
				end
			end
			sntr_pkg::OP_COMPARE: begin
				order_d = lt ? sntr_pkg::ORD_LESS
				             : (eq ? sntr_pkg::ORD_EQUAL : sntr_pkg::ORD_GREATER);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= '0;
			nanos_q <= '0;
		end else if (cmd.apply) begin
			sec_q   <= sec_d;
			nanos_q <= nanos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			order_q <= order_d;
			err_q   <= err_d;
		end
	end

	// Seconds times one billion is formed from two 32-bit halves.
	assign sec64 = 64'(sec_q);

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			lo_prod_q    <= 62'(sec64[31:0]) * 62'(sntr_pkg::NS_PER_SEC);
			micro_prod_q <= 61'(nanos_q) * 61'(sntr_pkg::MICRO_RECIP);
		end
		if (cmd.mul_hi) begin
			hi_prod_q <= 32'(64'(sec64[63:32]) * 64'(sntr_pkg::NS_PER_SEC));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.publish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			total_ns    <= 64'(lo_prod_q) + {hi_prod_q, 32'd0} + 64'(nanos_q);
			seconds_out <= sec64[sntr_pkg::OSEC_W-1:0];
			nanos_out   <= nanos_q;
			micros_out  <= micro_prod_q[sntr_pkg::MICRO_SHIFT +: sntr_pkg::MICRO_W];
			is_zero     <= (sec_q == '0) && (nanos_q == '0);
			order       <= order_q;
			error_code  <= err_q;
		end
	end

	assign done = done_q;

endmodule

FILE: hdl/sntr_ctrl.sv
// Controller state machine: sequences load, division steps, update, products and publish.
// Depends on sntr_pkg.
`timescale 1ns / 1ps

module sntr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output sntr_pkg::sntr_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV    = 3'd1;
	localparam logic [2:0] ST_APPLY  = 3'd2;
	localparam logic [2:0] ST_MUL_LO = 3'd3;
	localparam logic [2:0] ST_MUL_HI = 3'd4;
	localparam logic [2:0] ST_PUB    = 3'd5;

	localparam int CW = $clog2(sntr_pkg::DIV_STEPS);

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [CW-1:0] cnt_q;
	logic          last_step;

	assign last_step = cnt_q == CW'(sntr_pkg::DIV_STEPS - 1);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_PUB;
			end
			ST_PUB: begin
				cmd.publish = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	assign busy = state_q != ST_IDLE;

endmodule

FILE: bench/tb_seconds_nanoseconds_time_register_top.sv
// Self-checking testbench for the seconds and nanoseconds time register.
// Depends on sntr_pkg and seconds_nanoseconds_time_register_top; needs nothing else.
`timescale 1ns / 1ps

module tb_seconds_nanoseconds_time_register_top;

	// The bench predicts with the block's default seconds width.
	localparam int          SECW         = sntr_pkg::SEC_BITS_DEF;
	localparam logic [63:0] BILLION      = 64'd1000000000;
	localparam logic [63:0] NS_PER_MICRO = 64'd1000;
	localparam logic [63:0] SEC_MASK     =
		(SECW >= 64) ? ~64'd0 : ((64'd1 << SECW) - 64'd1);
	localparam logic [47:0] SEC_MAX      = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0] NS_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;

	// The spare opcode has no name in the package; the block treats it as a read.
	localparam logic [2:0] OP_SPARE = 3'd7;

	localparam int RANDOM_WORDS = 1700;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 1500000;

	// One result word, laid out as the block presents it.
	typedef struct packed {
		logic [63:0] total_ns;
		logic [47:0] seconds;
		logic [29:0] nanos;
		logic [19:0] micros;
		logic        zero;
		logic [1:0]  order;
		logic        error;
	} reading_t;

	// One directed stimulus row. Where typed is set, want holds the result read
	// straight off the specification; otherwise the predictor supplies it.
	typedef struct {
		logic [2:0]  op;
		logic [63:0] ns;
		logic [47:0] sec;
		bit          typed;
		reading_t    want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  opcode;
	logic [63:0] operand_ns;
	logic [47:0] operand_sec;
	logic        done;
	logic [63:0] total_ns;
	logic [47:0] seconds_out;
	logic [29:0] nanos_out;
	logic [19:0] micros_out;
	logic        is_zero;
	logic [1:0]  order;
	logic        error_code;

	// Predicted copy of the stored time, advanced as each word is accepted.
	logic [63:0] held_sec   = '0;
	logic [63:0] held_nanos = '0;

	reading_t  pending_readings[$];
	stim_row_t directed_rows[$];
	reading_t  oldest_reading;
	int        mismatches  = 0;
	int        cycle_count = 0;

	seconds_nanoseconds_time_register_top #(
		.SEC_BITS(SECW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.operand_ns(operand_ns),
		.operand_sec(operand_sec),
		.done(done),
		.total_ns(total_ns),
		.seconds_out(seconds_out),
		.nanos_out(nanos_out),
		.micros_out(micros_out),
		.is_zero(is_zero),
		.order(order),
		.error_code(error_code)
	);

	always #5 clk = ~clk;

	// The watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Ordering of two times given as seconds and nanoseconds. The operand
	// seconds may exceed the stored width, so everything is held in 64 bits.
	function automatic logic [1:0] time_order(logic [63:0] a_sec, logic [63:0] a_ns,
			logic [63:0] b_sec, logic [63:0] b_ns);
		if (a_sec < b_sec) return sntr_pkg::ORD_LESS;
		if (a_sec > b_sec) return sntr_pkg::ORD_GREATER;
		if (a_ns < b_ns) return sntr_pkg::ORD_LESS;
		if (a_ns > b_ns) return sntr_pkg::ORD_GREATER;
		return sntr_pkg::ORD_EQUAL;
	endfunction

	// Applies one operation to the predicted time and returns the word that the
	// block should report for it.
	task automatic apply_time_op(input logic [2:0] op, input logic [63:0] ns,
			input logic [47:0] sec, output reading_t res);
		logic [63:0] osec;
		logic [63:0] quot;
		logic [63:0] rem;
		logic [63:0] op_sec;
		logic [63:0] sum;
		logic [63:0] micros;
		logic [1:0]  ord;
		logic        err;
		osec   = {16'd0, sec} & SEC_MASK;
		quot   = ns / BILLION;
		rem    = ns - quot * BILLION;
		op_sec = osec + quot;
		ord    = sntr_pkg::ORD_LESS;
		err    = sntr_pkg::ERR_OK;
		case (op)
			sntr_pkg::OP_SET_NS: begin
				held_sec   = quot & SEC_MASK;
				held_nanos = rem;
			end
			sntr_pkg::OP_ADD_NS: begin
				sum = held_nanos + rem;
				if (sum >= BILLION) begin
					sum      = sum - BILLION;
					held_sec = held_sec + 64'd1;
				end
				held_nanos = sum;
				held_sec   = (held_sec + quot) & SEC_MASK;
			end
			sntr_pkg::OP_SET_SEC_NS: begin
				held_sec   = op_sec & SEC_MASK;
				held_nanos = rem;
			end
			sntr_pkg::OP_ADD_SEC: held_sec = (held_sec + osec) & SEC_MASK;
			sntr_pkg::OP_SUB_SEC_NS: begin
				// A subtraction that would go below zero leaves the time alone.
				if (time_order(held_sec, held_nanos, op_sec, rem) == sntr_pkg::ORD_LESS) begin
					err = sntr_pkg::ERR_NEGATIVE;
				end else if (held_nanos >= rem) begin
					held_nanos = held_nanos - rem;
					held_sec   = held_sec - op_sec;
				end else begin
					held_nanos = held_nanos + BILLION - rem;
					held_sec   = held_sec - op_sec - 64'd1;
				end
			end
			sntr_pkg::OP_COMPARE: ord = time_order(held_sec, held_nanos, op_sec, rem);
			default: ;
		endcase
		micros       = held_nanos / NS_PER_MICRO;
		res.total_ns = held_sec * BILLION + held_nanos;
		res.seconds  = held_sec[47:0];
		res.nanos    = held_nanos[29:0];
		res.micros   = micros[19:0];
		res.zero     = (held_sec == 64'd0) && (held_nanos == 64'd0);
		res.order    = ord;
		res.error    = err;
	endtask

	function automatic reading_t mk_reading(logic [63:0] tot, logic [47:0] sec,
			logic [29:0] nanos, logic [19:0] micros, logic zero, logic [1:0] ord,
			logic err);
		reading_t r;
		r.total_ns = tot;
		r.seconds  = sec;
		r.nanos    = nanos;
		r.micros   = micros;
		r.zero     = zero;
		r.order    = ord;
		r.error    = err;
		return r;
	endfunction

	task automatic add_row(input logic [2:0] op, input logic [63:0] ns,
			input logic [47:0] sec, input bit typed, input reading_t want);
		stim_row_t row;
		row.op    = op;
		row.ns    = ns;
		row.sec   = sec;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	function automatic void check_field(string label, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, label, want, got);
			mismatches++;
		end
	endfunction

	// Results are sampled at the edge that ends the cycle in which done is high,
	// so the values seen are the ones the block held through that cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: result word with nothing expected, total_ns got %0h",
					$time, total_ns);
				mismatches++;
			end else begin
				oldest_reading = pending_readings.pop_front();
				check_field("total_ns", oldest_reading.total_ns, total_ns);
				check_field("seconds_out", {16'd0, oldest_reading.seconds}, {16'd0, seconds_out});
				check_field("nanos_out", {34'd0, oldest_reading.nanos}, {34'd0, nanos_out});
				check_field("micros_out", {44'd0, oldest_reading.micros}, {44'd0, micros_out});
				check_field("is_zero", {63'd0, oldest_reading.zero}, {63'd0, is_zero});
				check_field("order", {62'd0, oldest_reading.order}, {62'd0, order});
				check_field("error_code", {63'd0, oldest_reading.error}, {63'd0, error_code});
			end
		end
	end

	// Mostly short gaps, now and then a long one that outlasts a whole division.
	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) return 0;
		if (pick < 85) return $urandom_range(1, 4);
		if (pick < 95) return $urandom_range(5, 20);
		return $urandom_range(30, 300);
	endfunction

	// Drops start for a while and puts junk on the operand ports, which the
	// block must ignore while start is low.
	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			start       <= 1'b0;
			opcode      <= 3'($urandom);
			operand_ns  <= {$urandom, $urandom};
			operand_sec <= 48'({$urandom, $urandom});
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Offers one word and holds it until the block takes it, that is until an
	// edge at which start is high and busy is low. The prediction is queued then.
	task automatic send_word(input logic [2:0] op, input logic [63:0] ns,
			input logic [47:0] sec, input bit typed, input reading_t want);
		reading_t predicted;
		start       <= 1'b1;
		opcode      <= op;
		operand_ns  <= ns;
		operand_sec <= sec;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_time_op(op, ns, sec, predicted);
		pending_readings.push_back(typed ? want : predicted);
	endtask

	// Nanosecond operands: mostly below a second, otherwise full-width values,
	// whole numbers of seconds plus a remainder, and the boundary values.
	function automatic logic [63:0] rand_ns();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 64'($urandom_range(0, 999999999));
			4, 5: return {$urandom, $urandom};
			6: return 64'($urandom_range(0, 40)) * BILLION + 64'($urandom_range(0, 999999999));
			7: begin
				case ($urandom_range(0, 3))
					0: return 64'd0;
					1: return BILLION - 64'd1;
					2: return BILLION;
					default: return NS_MAX;
				endcase
			end
			default: return {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
	endfunction

	function automatic logic [47:0] rand_sec();
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return wide[47:0];
			4, 5, 6: return 48'($urandom_range(0, 1000));
			7: return SEC_MAX;
			default: return held_sec[47:0] + 48'($urandom_range(0, 3));
		endcase
	endfunction

	initial begin
		int          gap;
		bit          calm;
		int          nudge;
		logic [2:0]  op;
		logic [63:0] ns;
		logic [47:0] sec;

		// Every input is known from time zero; reset is held low at the start.
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = sntr_pkg::OP_READ;
		operand_ns  = '0;
		operand_sec = '0;

		// Directed words, walked in order from the reset state. The typed results
		// are those that can be read off at a glance; the rest come from the
		// predictor.
		add_row(sntr_pkg::OP_READ, 64'd0, 48'd0, 1'b1,
			mk_reading(64'd0, 48'd0, 30'd0, 20'd0, 1'b1,
				sntr_pkg::ORD_LESS, sntr_pkg::ERR_OK));
		// Subtracting from zero must be refused and flagged.
		add_row(sntr_pkg::OP_SUB_SEC_NS, 64'd1, 48'd0, 1'b1,
			mk_reading(64'd0, 48'd0, 30'd0, 20'd0, 1'b1,
				sntr_pkg::ORD_LESS, sntr_pkg::ERR_NEGATIVE));
		// The largest nanosecond count splits into seconds and a remainder.
		add_row(sntr_pkg::OP_SET_NS, NS_MAX, 48'd0, 1'b1,
			mk_reading(NS_MAX, 48'd18446744073, 30'd709551615, 20'd709551, 1'b0,
				sntr_pkg::ORD_LESS, sntr_pkg::ERR_OK));
		add_row(sntr_pkg::OP_ADD_NS, BILLION - 64'd1, 48'd0, 1'b0, '0);
		add_row(sntr_pkg::OP_SET_SEC_NS, 64'd0, SEC_MAX, 1'b0, '0);
		// Seconds wrap back to zero; the nanosecond operand is ignored here.
		add_row(sntr_pkg::OP_ADD_SEC, NS_MAX, 48'd1, 1'b1,
			mk_reading(64'd0, 48'd0, 30'd0, 20'd0, 1'b1,
				sntr_pkg::ORD_LESS, sntr_pkg::ERR_OK));
		add_row(sntr_pkg::OP_SET_SEC_NS, NS_MAX, SEC_MAX, 1'b0, '0);
		// The operand time is compared unwrapped, so it exceeds the stored time.
		add_row(sntr_pkg::OP_COMPARE, NS_MAX, SEC_MAX, 1'b0, '0);
		add_row(sntr_pkg::OP_COMPARE, 64'd0, 48'd0, 1'b0, '0);
		add_row(sntr_pkg::OP_SET_NS, BILLION - 64'd1, 48'd0, 1'b1,
			mk_reading(64'd999999999, 48'd0, 30'd999999999, 20'd999999, 1'b0,
				sntr_pkg::ORD_LESS, sntr_pkg::ERR_OK));
		add_row(sntr_pkg::OP_COMPARE, BILLION - 64'd1, 48'd0, 1'b1,
			mk_reading(64'd999999999, 48'd0, 30'd999999999, 20'd999999, 1'b0,
				sntr_pkg::ORD_EQUAL, sntr_pkg::ERR_OK));
		add_row(sntr_pkg::OP_COMPARE, BILLION, 48'd0, 1'b0, '0);
		add_row(sntr_pkg::OP_SUB_SEC_NS, BILLION, 48'd0, 1'b1,
			mk_reading(64'd999999999, 48'd0, 30'd999999999, 20'd999999, 1'b0,
				sntr_pkg::ORD_LESS, sntr_pkg::ERR_NEGATIVE));
		add_row(sntr_pkg::OP_ADD_NS, 64'd1, 48'd0, 1'b0, '0);
		// Borrow from the seconds, then subtract down to exactly zero.
		add_row(sntr_pkg::OP_SUB_SEC_NS, 64'd1, 48'd0, 1'b0, '0);
		add_row(sntr_pkg::OP_SUB_SEC_NS, BILLION - 64'd1, 48'd0, 1'b1,
			mk_reading(64'd0, 48'd0, 30'd0, 20'd0, 1'b1,
				sntr_pkg::ORD_LESS, sntr_pkg::ERR_OK));
		add_row(OP_SPARE, NS_MAX, SEC_MAX, 1'b0, '0);
		add_row(sntr_pkg::OP_SET_SEC_NS, 64'd3000000123, 48'd5, 1'b0, '0);
		add_row(sntr_pkg::OP_SUB_SEC_NS, 64'd124, 48'd8, 1'b0, '0);
		add_row(sntr_pkg::OP_SUB_SEC_NS, 64'd1000000123, 48'd7, 1'b0, '0);
		add_row(sntr_pkg::OP_ADD_SEC, 64'd0, SEC_MAX, 1'b0, '0);
		add_row(sntr_pkg::OP_ADD_NS, NS_MAX, 48'd0, 1'b0, '0);
		add_row(sntr_pkg::OP_READ, NS_MAX, SEC_MAX, 1'b0, '0);
		add_row(sntr_pkg::OP_COMPARE, 64'd0, 48'd0, 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			idle_for(pick_gap());
			send_word(directed_rows[i].op, directed_rows[i].ns, directed_rows[i].sec,
				directed_rows[i].typed, directed_rows[i].want);
		end

		// Random words. Subtractions and comparisons are aimed at the stored time
		// half of the time, so that equal, just-below and just-above operands all
		// turn up rather than mostly refused subtractions.
		calm = 1'b0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			gap = calm ? 0 : pick_gap();
			op  = 3'($urandom_range(0, 7));
			ns  = rand_ns();
			sec = rand_sec();
			if ((op == sntr_pkg::OP_SUB_SEC_NS || op == sntr_pkg::OP_COMPARE)
					&& $urandom_range(0, 1) == 1) begin
				nudge = $urandom_range(0, 2);
				sec   = held_sec[47:0] - 48'($urandom_range(0, 1));
				case (nudge)
					0: ns = (held_nanos == 64'd0) ? 64'd0 : held_nanos - 64'd1;
					1: ns = held_nanos;
					default: ns = held_nanos + 64'd1;
				endcase
			end
			idle_for(gap);
			send_word(op, ns, sec, 1'b0, '0);
		end
		start <= 1'b0;

		// Let every queued result arrive, then a little longer to catch strays.
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: seconds_nanoseconds_time_register_top.f
+incdir+hdl
hdl/sntr_pkg.sv
hdl/sntr_div.sv
hdl/sntr_datapath.sv
hdl/sntr_ctrl.sv
hdl/seconds_nanoseconds_time_register_top.sv
bench/tb_seconds_nanoseconds_time_register_top.sv
